// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/msed_pkg.sv =====
// Types and constants of the MIDI stream event decoder.
package msed_pkg;

   localparam int SYSEX_CAPACITY_DEF = 64;
   localparam int LEN_W              = 7;
   localparam int HEAD_DEPTH         = 6;
   localparam int HEAD_IDX_W         = 3;

   localparam logic [7:0] ST_SYSEX_START = 8'hF0;
   localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
   localparam logic [3:0] ST_CTRL_CHANGE = 4'hB;
   localparam logic [7:0] MFR_ID         = 8'h7D;

   localparam logic [7:0] CMD_ORDER    = 8'h01;
   localparam logic [7:0] CMD_HIGHPASS = 8'h04;
   localparam logic [7:0] CMD_LOWPASS  = 8'h05;
   localparam logic [7:0] CMD_TEMPO    = 8'h06;
   localparam logic [7:0] CMD_RADIO    = 8'h20;

   typedef enum logic [2:0] {
      EV_CONTROL  = 3'd0,
      EV_SWITCH   = 3'd1,
      EV_ORDER    = 3'd2,
      EV_HIGHPASS = 3'd3,
      EV_LOWPASS  = 3'd4,
      EV_TEMPO    = 3'd5,
      EV_RADIO    = 3'd6
   } event_kind_type;

endpackage

// ===== design/midi_stream_event_decoder_top.sv =====
// MIDI byte stream parser with running status and manufacturer SysEx decode.
// Pipeline: an accepted item goes through the input register, then the result register.
// Throughput: one item per cycle; req_stall rises only while the result
//    register holds an item that the receiver stalls.
// Reset: synchronous, active high; clears parser state and both valid flags.
// The SysEx head bytes are not reset; reads are guarded by the frame length.
`include "assert_macros.svh"

module midi_stream_event_decoder_top #(
   parameter int SYSEX_CAPACITY = msed_pkg::SYSEX_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel: one MIDI byte per item
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_midi_byte,
   // result channel: one decoded event per item
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [6:0]  rsp_ctrl_number,
   output logic [6:0]  rsp_ctrl_value,
   output logic [7:0]  rsp_slot_or_index,
   output logic [15:0] rsp_wide_value,
   output logic [7:0]  rsp_order_first,
   output logic [7:0]  rsp_order_second,
   output logic [7:0]  rsp_order_third,
   output logic [7:0]  rsp_order_fourth
);
   import msed_pkg::*;

   localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(SYSEX_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_HEAD = LEN_W'(HEAD_DEPTH);

   // ---------------------------------------------------------------
   // Input register: holds the byte under decode.
   // ---------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // ---------------------------------------------------------------
   // Parser state.
   // ---------------------------------------------------------------
   logic [7:0]       running_status_ff, running_status_in;
   logic             held_valid_ff, held_valid_in;
   logic [6:0]       held_byte_ff, held_byte_in;
   logic             in_sysex_ff, in_sysex_in;
   logic [LEN_W-1:0] sysex_length_ff, sysex_length_in;
   logic [7:0]       sysex_head_ff [HEAD_DEPTH];
   logic             head_we;

   // ---------------------------------------------------------------
   // Result register.
   // ---------------------------------------------------------------
   logic           out_valid_ff;
   event_kind_type kind_ff, kind_in;
   logic [6:0]     ctrl_number_ff, ctrl_number_in;
   logic [6:0]     ctrl_value_ff, ctrl_value_in;
   logic [7:0]     slot_ff, slot_in;
   logic [15:0]    wide_ff, wide_in;
   logic [7:0]     order0_ff, order0_in;
   logic [7:0]     order1_ff, order1_in;
   logic [7:0]     order2_ff, order2_in;
   logic [7:0]     order3_ff, order3_in;
   logic           emit;

   // The decode stage moves on whenever the result register is free or
   // being emptied this cycle; that same condition frees the input register.
   logic advance;
   logic dec_fire;
   logic is_start;
   logic is_end;
   logic [7:0] cmd;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign dec_fire  = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign is_start = (in_byte_ff == ST_SYSEX_START);
   assign is_end   = (in_byte_ff == ST_SYSEX_END);
   assign cmd      = sysex_head_ff[1];

   // ---------------------------------------------------------------
   // Decode: next state and the optional result for the held byte.
   // ---------------------------------------------------------------
   always_comb begin
      running_status_in = running_status_ff;
      held_valid_in     = held_valid_ff;
      held_byte_in      = held_byte_ff;
      in_sysex_in       = in_sysex_ff;
      sysex_length_in   = sysex_length_ff;
      head_we           = 1'b0;

      emit           = 1'b0;
      kind_in        = EV_CONTROL;
      ctrl_number_in = '0;
      ctrl_value_in  = '0;
      slot_in        = '0;
      wide_in        = '0;
      order0_in      = '0;
      order1_in      = '0;
      order2_in      = '0;
      order3_in      = '0;

      if (is_start) begin
         // open (or restart) a frame
         in_sysex_in     = 1'b1;
         sysex_length_in = '0;
      end else if (is_end) begin
         // close the frame; a stray end byte outside SysEx is dropped
         if (in_sysex_ff) begin
            in_sysex_in = 1'b0;
            if (sysex_length_ff >= LEN_W'(2) && sysex_head_ff[0] == MFR_ID) begin
               if (cmd == CMD_ORDER && sysex_length_ff >= LEN_W'(6)) begin
                  emit      = 1'b1;
                  kind_in   = EV_ORDER;
                  order0_in = sysex_head_ff[2];
                  order1_in = sysex_head_ff[3];
                  order2_in = sysex_head_ff[4];
                  order3_in = sysex_head_ff[5];
               end else if ((cmd == CMD_HIGHPASS || cmd == CMD_LOWPASS)
                            && sysex_length_ff >= LEN_W'(5)) begin
                  emit    = 1'b1;
                  kind_in = (cmd == CMD_LOWPASS) ? EV_LOWPASS : EV_HIGHPASS;
                  slot_in = sysex_head_ff[2];
                  wide_in = {1'b0, sysex_head_ff[3], 7'b0} | {8'b0, sysex_head_ff[4]};
               end else if (cmd == CMD_TEMPO && sysex_length_ff >= LEN_W'(4)) begin
                  emit    = 1'b1;
                  kind_in = EV_TEMPO;
                  wide_in = {1'b0, sysex_head_ff[2], 7'b0} | {8'b0, sysex_head_ff[3]};
               end else if (cmd == CMD_RADIO) begin
                  emit    = 1'b1;
                  kind_in = EV_RADIO;
               end
            end
         end
      end else if (in_sysex_ff) begin
         // collect frame content; keep the head, saturate the length
         if (sysex_length_ff < LEN_CAP) begin
            head_we         = (sysex_length_ff < LEN_HEAD);
            sysex_length_in = sysex_length_ff + LEN_W'(1);
         end
      end else if (in_byte_ff[7]) begin
         // any other status byte becomes running status
         running_status_in = in_byte_ff;
         held_valid_in     = 1'b0;
      end else if (!held_valid_ff) begin
         held_byte_in  = in_byte_ff[6:0];
         held_valid_in = 1'b1;
      end else begin
         // second data byte completes a pair
         held_valid_in = 1'b0;
         if (running_status_ff[7:4] == ST_CTRL_CHANGE) begin
            emit           = 1'b1;
            ctrl_number_in = held_byte_ff;
            ctrl_value_in  = in_byte_ff[6:0];
            if (held_byte_ff[6:2] == 5'b10000) begin
               // sustain-range controllers 64 to 67 report as switches
               kind_in = EV_SWITCH;
               slot_in = {6'b0, held_byte_ff[1:0]};
               wide_in = {15'b0, in_byte_ff[6]};
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Input register.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_midi_byte;
      end
   end

   // ---------------------------------------------------------------
   // Parser state: advance only when the held byte is consumed.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= '0;
         held_valid_ff     <= 1'b0;
         held_byte_ff      <= '0;
         in_sysex_ff       <= 1'b0;
         sysex_length_ff   <= '0;
      end else if (dec_fire) begin
         running_status_ff <= running_status_in;
         held_valid_ff     <= held_valid_in;
         held_byte_ff      <= held_byte_in;
         in_sysex_ff       <= in_sysex_in;
         sysex_length_ff   <= sysex_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_fire && head_we) begin
         sysex_head_ff[sysex_length_ff[HEAD_IDX_W-1:0]] <= in_byte_ff;
      end
   end

   // ---------------------------------------------------------------
   // Result register: load on a result, drop when taken.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dec_fire && emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_fire && emit) begin
         kind_ff        <= kind_in;
         ctrl_number_ff <= ctrl_number_in;
         ctrl_value_ff  <= ctrl_value_in;
         slot_ff        <= slot_in;
         wide_ff        <= wide_in;
         order0_ff      <= order0_in;
         order1_ff      <= order1_in;
         order2_ff      <= order2_in;
         order3_ff      <= order3_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_ctrl_number   = ctrl_number_ff;
   assign rsp_ctrl_value    = ctrl_value_ff;
   assign rsp_slot_or_index = slot_ff;
   assign rsp_wide_value    = wide_ff;
   assign rsp_order_first   = order0_ff;
   assign rsp_order_second  = order1_ff;
   assign rsp_order_third   = order2_ff;
   assign rsp_order_fourth  = order3_ff;

   // ---------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------
   // frame length never passes its saturation point
   `ASSERT_SAME(a_len_cap, clock, reset, 1'b1, sysex_length_ff <= LEN_CAP)
   // a consumed end byte always leaves the frame closed
   `ASSERT_NEXT(a_end_closes, clock, reset, dec_fire && is_end, !in_sysex_ff)
   // input backpressure only comes from a stalled, full result register
   `ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall && in_valid_ff)

endmodule

// ===== bench/midi_event_checker.sv =====
// Checker for the MIDI stream event decoder: predicts events and compares results.
module midi_event_checker #(
   parameter int SYSEX_CAPACITY = msed_pkg::SYSEX_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_midi_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_event_kind,
   input  logic [6:0]  rsp_ctrl_number,
   input  logic [6:0]  rsp_ctrl_value,
   input  logic [7:0]  rsp_slot_or_index,
   input  logic [15:0] rsp_wide_value,
   input  logic [7:0]  rsp_order_first,
   input  logic [7:0]  rsp_order_second,
   input  logic [7:0]  rsp_order_third,
   input  logic [7:0]  rsp_order_fourth,
   output int          mismatches,
   output int          events_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import msed_pkg::*;

   // Controllers 64..67 are the switch controllers.
   localparam logic [6:0] SWITCH_BASE = 7'd64;

   typedef struct packed {
      event_kind_type kind;
      logic [6:0]     ctrl_number;
      logic [6:0]     ctrl_value;
      logic [7:0]     slot_or_index;
      logic [15:0]    wide_value;
      logic [7:0]     order_first;
      logic [7:0]     order_second;
      logic [7:0]     order_third;
      logic [7:0]     order_fourth;
   } decoded_event_type;

   // Parser state mirrored from the accepted byte stream.
   logic [7:0] running_status;
   logic       held_valid;
   logic [6:0] held_byte;
   logic       in_frame;
   int         frame_len;
   logic [7:0] frame_head [HEAD_DEPTH];

   decoded_event_type expected_events [$];
   int                fail_count = 0;

   // Advance the parser by one byte; return 1 when the byte completes an event.
   function automatic bit advance_parser(input logic [7:0] b, output decoded_event_type ev);
      logic [7:0] cmd;
      ev = '0;
      advance_parser = 1'b0;
      if (b == ST_SYSEX_START) begin
         in_frame  = 1'b1;
         frame_len = 0;
      end else if (b == ST_SYSEX_END) begin
         // a stray end byte outside a frame changes nothing
         if (in_frame) begin
            in_frame = 1'b0;
            if (frame_len >= 2 && frame_head[0] == MFR_ID) begin
               cmd = frame_head[1];
               if (cmd == CMD_ORDER && frame_len >= 6) begin
                  ev.kind         = EV_ORDER;
                  ev.order_first  = frame_head[2];
                  ev.order_second = frame_head[3];
                  ev.order_third  = frame_head[4];
                  ev.order_fourth = frame_head[5];
                  advance_parser  = 1'b1;
               end else if ((cmd == CMD_HIGHPASS || cmd == CMD_LOWPASS) && frame_len >= 5) begin
                  ev.kind          = (cmd == CMD_LOWPASS) ? EV_LOWPASS : EV_HIGHPASS;
                  ev.slot_or_index = frame_head[2];
                  ev.wide_value    = ({8'd0, frame_head[3]} << 7) | {8'd0, frame_head[4]};
                  advance_parser   = 1'b1;
               end else if (cmd == CMD_TEMPO && frame_len >= 4) begin
                  ev.kind        = EV_TEMPO;
                  ev.wide_value  = ({8'd0, frame_head[2]} << 7) | {8'd0, frame_head[3]};
                  advance_parser = 1'b1;
               end else if (cmd == CMD_RADIO) begin
                  ev.kind        = EV_RADIO;
                  advance_parser = 1'b1;
               end
            end
         end
      end else if (in_frame) begin
         if (frame_len < SYSEX_CAPACITY) begin
            if (frame_len < HEAD_DEPTH) frame_head[HEAD_IDX_W'(frame_len)] = b;
            frame_len++;
         end
      end else if (b[7]) begin
         running_status = b;
         held_valid     = 1'b0;
      end else if (!held_valid) begin
         held_byte  = b[6:0];
         held_valid = 1'b1;
      end else begin
         held_valid = 1'b0;
         if (running_status[7:4] == ST_CTRL_CHANGE) begin
            ev.ctrl_number = held_byte;
            ev.ctrl_value  = b[6:0];
            if (held_byte[6:2] == SWITCH_BASE[6:2]) begin
               ev.kind          = EV_SWITCH;
               ev.slot_or_index = {1'b0, held_byte - SWITCH_BASE};
               ev.wide_value    = {15'd0, b[6]};
            end else begin
               ev.kind = EV_CONTROL;
            end
            advance_parser = 1'b1;
         end
      end
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got)
         report_failure($sformatf("%s expected %0d got %0d", field, want, got));
   endtask

   always @(posedge clock) begin : watch
      decoded_event_type ev;
      if (reset) begin
         running_status = 8'h00;
         held_valid     = 1'b0;
         held_byte      = 7'd0;
         in_frame       = 1'b0;
         frame_len      = 0;
         expected_events.delete();
      end else begin
         // compare before predicting: a result never belongs to this edge's byte
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               report_failure($sformatf("unexpected result of kind %0d", rsp_event_kind));
            end else begin
               ev = expected_events.pop_front();
               check_field("event_kind", 16'(ev.kind), 16'(rsp_event_kind));
               check_field("ctrl_number", 16'(ev.ctrl_number), 16'(rsp_ctrl_number));
               check_field("ctrl_value", 16'(ev.ctrl_value), 16'(rsp_ctrl_value));
               check_field("slot_or_index", 16'(ev.slot_or_index), 16'(rsp_slot_or_index));
               check_field("wide_value", ev.wide_value, rsp_wide_value);
               check_field("order_first", 16'(ev.order_first), 16'(rsp_order_first));
               check_field("order_second", 16'(ev.order_second), 16'(rsp_order_second));
               check_field("order_third", 16'(ev.order_third), 16'(rsp_order_third));
               check_field("order_fourth", 16'(ev.order_fourth), 16'(rsp_order_fourth));
            end
         end
         if (req_valid && !req_stall) begin
            if (advance_parser(req_midi_byte, ev)) expected_events.push_back(ev);
         end
      end
      mismatches     <= fail_count;
      events_pending <= expected_events.size();
   end

endmodule

// ===== bench/tb_midi_stream_event_decoder_top.sv =====
// Testbench top for the MIDI stream event decoder: stimulus, stalls and verdict.
module tb_midi_stream_event_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;
   import msed_pkg::*;

   // Number of byte items after which the random part stops.
   localparam int RANDOM_ITEMS = 720;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_midi_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [6:0]  rsp_ctrl_number;
   logic [6:0]  rsp_ctrl_value;
   logic [7:0]  rsp_slot_or_index;
   logic [15:0] rsp_wide_value;
   logic [7:0]  rsp_order_first;
   logic [7:0]  rsp_order_second;
   logic [7:0]  rsp_order_third;
   logic [7:0]  rsp_order_fourth;

   int mismatches;
   int events_pending;
   int bytes_sent    = 0;
   int sink_hold     = 0;
   bit steady_source = 1'b0;
   bit steady_sink   = 1'b0;

   always #5 clock = ~clock;

   midi_stream_event_decoder_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_midi_byte     (req_midi_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_ctrl_number   (rsp_ctrl_number),
      .rsp_ctrl_value    (rsp_ctrl_value),
      .rsp_slot_or_index (rsp_slot_or_index),
      .rsp_wide_value    (rsp_wide_value),
      .rsp_order_first   (rsp_order_first),
      .rsp_order_second  (rsp_order_second),
      .rsp_order_third   (rsp_order_third),
      .rsp_order_fourth  (rsp_order_fourth)
   );

   // The checker watches both channels and counts failures for the verdict.
   midi_event_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_midi_byte     (req_midi_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_ctrl_number   (rsp_ctrl_number),
      .rsp_ctrl_value    (rsp_ctrl_value),
      .rsp_slot_or_index (rsp_slot_or_index),
      .rsp_wide_value    (rsp_wide_value),
      .rsp_order_first   (rsp_order_first),
      .rsp_order_second  (rsp_order_second),
      .rsp_order_third   (rsp_order_third),
      .rsp_order_fourth  (rsp_order_fourth),
      .mismatches        (mismatches),
      .events_pending    (events_pending)
   );

   // Gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Content byte of a SysEx frame: anything but the frame start and end bytes,
   // half of the time limited to data values.
   function automatic logic [7:0] frame_byte();
      logic [7:0] b;
      do begin
         b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
      end while (b == ST_SYSEX_START || b == ST_SYSEX_END);
      return b;
   endfunction

   // Offer one item after a random gap and hold it until it is accepted.
   // Keep valid high between back-to-back items so it is never dropped and
   // raised in the same step.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = steady_source ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_midi_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Receiver: stall in runs of random length, with quiet stretches when
   // steady_sink is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_hold <= 0;
      end else if (sink_hold > 0) begin
         rsp_stall <= 1'b1;
         sink_hold <= sink_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!steady_sink && $urandom_range(0, 3) == 0) sink_hold <= pick_gap();
      end
   end

   // Hard limit on the run: far beyond the slowest legal run.
   initial begin
      #(5_000_000);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int         roll;
      int         pairs;
      int         need;
      int         shape;
      int         keep;
      logic [6:0] cc;
      logic [7:0] cmd;
      logic [7:0] st;
      logic [7:0] frame [$];

      // Hold reset from time zero, then release it once for the whole run.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- Directed part ----
      // Data bytes before any status: consumed as a pair, no event.
      send_byte(8'h00);
      send_byte(8'h7F);
      // Stray frame end outside SysEx: ignored.
      send_byte(ST_SYSEX_END);
      // Control change on channel 15, first switch controller, on.
      send_byte({ST_CTRL_CHANGE, 4'hF});
      send_byte(8'h40);
      send_byte(8'h7F);
      // Running status: last switch controller, off at the threshold edge.
      send_byte(8'h43);
      send_byte(8'h3F);
      // Real-time byte outside SysEx: becomes running status, kills CC decode.
      send_byte(8'hF8);
      // Low-pass frame with extreme slot and cutoff bytes.
      send_byte(ST_SYSEX_START);
      send_byte(MFR_ID);
      send_byte(CMD_LOWPASS);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(ST_SYSEX_END);
      // Frame start inside a frame restarts it; radio request follows.
      send_byte(ST_SYSEX_START);
      send_byte(ST_SYSEX_START);
      send_byte(MFR_ID);
      send_byte(CMD_RADIO);
      send_byte(ST_SYSEX_END);

      // ---- Random part ----
      while (bytes_sent < RANDOM_ITEMS) begin
         // Switch idling modes now and then so some stretches run with no gaps.
         if ($urandom_range(0, 15) == 0) begin
            steady_source = ($urandom_range(0, 3) == 0);
            steady_sink  <= ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 19);
         if (roll < 7) begin
            // Control changes: optionally a fresh CC status, then pairs,
            // with controllers biased around the switch range.
            if ($urandom_range(0, 2) != 0) send_byte({ST_CTRL_CHANGE, 4'($urandom_range(0, 15))});
            pairs = $urandom_range(1, 5);
            repeat (pairs) begin
               cc = $urandom_range(0, 1) ? 7'($urandom_range(60, 71)) : 7'($urandom_range(0, 127));
               send_byte({1'b0, cc});
               send_byte({1'b0, 7'($urandom_range(0, 127))});
            end
         end else if (roll < 12) begin
            // SysEx frame: mostly well formed, some short, long, restarted
            // or left open.
            need = $urandom_range(0, 11);
            if (need < 2) begin
               cmd  = CMD_ORDER;
               need = 4;
            end else if (need < 4) begin
               cmd  = CMD_HIGHPASS;
               need = 3;
            end else if (need < 6) begin
               cmd  = CMD_LOWPASS;
               need = 3;
            end else if (need < 8) begin
               cmd  = CMD_TEMPO;
               need = 2;
            end else if (need < 10) begin
               cmd  = CMD_RADIO;
               need = 0;
            end else begin
               cmd  = frame_byte();
               need = $urandom_range(0, 4);
            end
            frame.delete();
            frame.push_back(($urandom_range(0, 19) == 0) ? frame_byte() : MFR_ID);
            frame.push_back(cmd);
            repeat (need) frame.push_back(frame_byte());
            shape = $urandom_range(0, 19);
            if (shape >= 10 && shape < 14) begin
               repeat ($urandom_range(1, 3)) frame.push_back(frame_byte());
            end else if (shape >= 14 && shape < 17) begin
               // truncate below what the command needs, possibly to nothing
               keep = $urandom_range(0, need + 1);
               while (frame.size() > keep) void'(frame.pop_back());
            end else if (shape == 17) begin
               // run the length up to or past the capacity
               repeat ($urandom_range(56, 70)) frame.push_back(frame_byte());
            end
            send_byte(ST_SYSEX_START);
            if (shape == 18) begin
               // abandon a partial frame and restart it
               repeat ($urandom_range(1, 4)) send_byte(frame_byte());
               send_byte(ST_SYSEX_START);
            end
            foreach (frame[i]) send_byte(frame[i]);
            if (shape != 19) send_byte(ST_SYSEX_END);
         end else if (roll < 15) begin
            // Other channel message: data consumed in pairs, odd counts
            // leave a byte held for the next status to drop.
            do st = 8'($urandom_range(8'h80, 8'hEF)); while (st[7:4] == ST_CTRL_CHANGE);
            send_byte(st);
            repeat ($urandom_range(1, 5)) send_byte({1'b0, 7'($urandom_range(0, 127))});
         end else if (roll < 17) begin
            // Bare data bytes under whatever running status stands.
            repeat ($urandom_range(1, 4)) send_byte({1'b0, 7'($urandom_range(0, 127))});
         end else begin
            // Noise: any byte value at all.
            send_byte(8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      // ---- Drain ----
      // Let the pending count catch up with the last accepted item, wait for
      // every expected event, then a few more cycles to catch extras.
      @(posedge clock);
      while (events_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && events_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
